/* sv/rk4i_pkg.sv */
// ---------------------------------------------------------------------------
// rk4i_pkg
// Shared widths, codes, pipeline payload types and small arithmetic helpers
// for the fourth-order Runge-Kutta stage integrator.
// ---------------------------------------------------------------------------
package rk4i_pkg;

  // Field widths
  localparam int VAL_W   = 32;              // signed Q16.16 values and clocks
  localparam int FRAC_W  = 16;              // fraction bits
  localparam int STEP_W  = 31;              // unsigned step size h
  localparam int SUM_W   = 35;              // k1 + 2*k2 + 2*k3 + k4
  localparam int LO_W    = 17;              // low slice of the split multiply
  localparam int HI_W    = SUM_W - LO_W;    // signed high slice
  localparam int PHI_W   = STEP_W + 1 + HI_W;
  localparam int PLO_W   = STEP_W + LO_W;
  localparam int PROD_W  = 66;              // exact h * sum
  localparam int INC_W   = PROD_W - FRAC_W; // increment before saturation
  localparam int SAT_W   = INC_W + 1;
  localparam int T_LSB   = FRAC_W + 1;      // floor(p / 2^17) before the /3
  localparam int QLO_W   = 24;              // low part of the /3 split
  localparam int Q_W     = QLO_W + 2;       // divide-by-3 operand width
  localparam int MOD_DIG = (Q_W + 3) / 4;   // hex digits of a /3 operand

  // Reset value of h
  localparam logic [STEP_W-1:0] STEP_SIZE_RST = 31'd655;

  // Divide by 3: floor(x * ceil(2^27 / 3) / 2^27) is exact for x < 2^27
  localparam logic [Q_W-1:0] DIV3_MAGIC = 26'd44739243;
  localparam int             DIV3_SHIFT = 27;
  // 3 * 2^24, makes a signed 25-bit operand non-negative
  localparam logic [Q_W-1:0] DIV3_BIAS  = 26'd50331648;

  // Saturation limits
  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  // Item action codes
  localparam logic ACT_EVAL    = 1'b0;
  localparam logic ACT_RESTART = 1'b1;

  // Runge-Kutta stage
  typedef enum logic [1:0] {
    STG_K1 = 2'd0,
    STG_K2 = 2'd1,
    STG_K3 = 2'd2,
    STG_K4 = 2'd3
  } stage_t;

  // Per-item fields carried alongside the arithmetic
  typedef struct packed {
    logic signed [VAL_W-1:0] x0;
    logic [1:0]              stage_done;
    logic                    step_complete;
    logic [VAL_W-1:0]        stage_time;
    logic [VAL_W-1:0]        step_time;
    logic                    use_div;
  } side_t;

  // Accepted item: multiplier and slope operand
  typedef struct packed {
    side_t                   side;
    logic [STEP_W-1:0]       mult;
    logic signed [SUM_W-1:0] slope;
  } op_t;

  // Partial products
  typedef struct packed {
    side_t                   side;
    logic signed [PHI_W-1:0] prod_hi;
    logic [PLO_W-1:0]        prod_lo;
  } prod_t;

  // Exact product
  typedef struct packed {
    side_t                    side;
    logic signed [PROD_W-1:0] prod;
  } full_t;

  // First half of the divide by 3
  typedef struct packed {
    side_t                   side;
    logic signed [QLO_W-1:0] quo_hi;
    logic [1:0]              rem_hi;
    logic [QLO_W-1:0]        t_lo;
    logic signed [INC_W-1:0] inc_dir;
  } split_t;

  // Final increment
  typedef struct packed {
    side_t                   side;
    logic signed [INC_W-1:0] inc;
  } inc_t;

  // floor(x / 3) for a 26-bit unsigned x
  function automatic logic [Q_W-2:0] div3(input logic [Q_W-1:0] x);
    logic [2*Q_W-1:0] prod;
    prod = x * DIV3_MAGIC;
    return prod[DIV3_SHIFT +: Q_W-1];
  endfunction

  // x mod 3 by digit folding (16 and 4 are both 1 mod 3)
  function automatic logic [1:0] mod3(input logic [Q_W-1:0] x);
    logic [4*MOD_DIG-1:0] xp;
    logic [6:0]           s1;
    logic [3:0]           s2;
    logic [2:0]           s3;
    xp = (4*MOD_DIG)'(x);
    s1 = '0;
    for (int i = 0; i < MOD_DIG; i++) begin
      s1 = s1 + 7'(xp[4*i +: 4]);
    end
    s2 = 4'(s1[1:0]) + 4'(s1[3:2]) + 4'(s1[5:4]) + 4'(s1[6]);
    s3 = 3'(s2[1:0]) + 3'(s2[3:2]);
    if (s3 >= 3'd3) begin
      s3 = s3 - 3'd3;
    end
    return s3[1:0];
  endfunction

endpackage

/* sv/rk4i_if.sv */
// ---------------------------------------------------------------------------
// rk4i_if
// Valid/ready channels of the stage integrator: evaluation items in,
// stage results out.
// ---------------------------------------------------------------------------
interface rk4i_in_if;
  import rk4i_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    action;
  logic signed [VAL_W-1:0] current_value;
  logic signed [VAL_W-1:0] derivative;

  modport source (output valid, action, current_value, derivative, input ready);
  modport sink   (input valid, action, current_value, derivative, output ready);
endinterface

interface rk4i_out_if;
  import rk4i_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] next_value;
  logic [1:0]              stage_done;
  logic                    step_complete;
  logic [VAL_W-1:0]        stage_time;
  logic [VAL_W-1:0]        step_time;

  modport source (output valid, next_value, stage_done, step_complete, stage_time,
                  step_time, input ready);
  modport sink   (input valid, next_value, stage_done, step_complete, stage_time,
                  step_time, output ready);
endinterface

/* sv/rk4i_ctl.sv */
// ---------------------------------------------------------------------------
// rk4i_ctl
// Input stage: step register, stage counter, start value and slopes,
// evaluation and step clocks; builds the multiply operands of each item.
// ---------------------------------------------------------------------------
module rk4i_ctl (
  input  logic                        clk,
  input  logic                        rst_n,
  rk4i_in_if.sink                     in_ch,
  input  logic                        cfg_we,
  input  logic [rk4i_pkg::STEP_W-1:0] cfg_data,
  output logic                        op_valid,
  input  logic                        op_ready,
  output rk4i_pkg::op_t               op
);
  import rk4i_pkg::*;

  logic [STEP_W-1:0]       step_size_r, step_size_nxt;
  stage_t                  stage_r, stage_nxt;
  logic signed [VAL_W-1:0] start_value_r, start_value_nxt;
  logic signed [VAL_W-1:0] slope_one_r, slope_one_nxt;
  logic signed [VAL_W-1:0] slope_two_r, slope_two_nxt;
  logic signed [VAL_W-1:0] slope_three_r, slope_three_nxt;
  logic [VAL_W-1:0]        eval_time_r, eval_time_nxt;
  logic [VAL_W-1:0]        full_step_time_r, full_step_time_nxt;
  logic                    op_valid_r, op_valid_nxt;
  op_t                     op_r, op_nxt;
  logic [STEP_W-1:0]       half;
  logic                    accept;

  assign in_ch.ready = !op_valid_r || op_ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign op_valid    = op_valid_r;
  assign op          = op_r;

  // Next state and operands, as if the current item is accepted
  always_comb begin
    half               = {1'b0, step_size_r[STEP_W-1:1]};
    step_size_nxt      = cfg_we ? cfg_data : step_size_r;
    op_valid_nxt       = in_ch.ready ? in_ch.valid : op_valid_r;
    stage_nxt          = stage_r;
    start_value_nxt    = start_value_r;
    slope_one_nxt      = slope_one_r;
    slope_two_nxt      = slope_two_r;
    slope_three_nxt    = slope_three_r;
    eval_time_nxt      = eval_time_r;
    full_step_time_nxt = full_step_time_r;

    op_nxt                    = '0;
    op_nxt.side.x0            = start_value_r;
    op_nxt.side.stage_done    = stage_r;
    op_nxt.mult               = step_size_r;
    op_nxt.slope              = SUM_W'(in_ch.derivative);

    if (in_ch.action == ACT_RESTART) begin
      // restart: clocks cleared, value passed straight through
      stage_nxt              = STG_K1;
      eval_time_nxt          = '0;
      full_step_time_nxt     = '0;
      op_nxt.side.x0         = in_ch.current_value;
      op_nxt.side.stage_done = STG_K1;
      op_nxt.mult            = '0;
      op_nxt.slope           = '0;
    end else begin
      case (stage_r)
        STG_K1: begin
          start_value_nxt = in_ch.current_value;
          slope_one_nxt   = in_ch.derivative;
          op_nxt.side.x0  = in_ch.current_value;
          op_nxt.mult     = half;
          eval_time_nxt   = eval_time_r + VAL_W'(half);
          stage_nxt       = STG_K2;
        end
        STG_K2: begin
          slope_two_nxt = in_ch.derivative;
          op_nxt.mult   = half;
          stage_nxt     = STG_K3;
        end
        STG_K3: begin
          slope_three_nxt = in_ch.derivative;
          eval_time_nxt   = eval_time_r + VAL_W'(half);
          stage_nxt       = STG_K4;
        end
        STG_K4: begin
          // weighted slope sum, divided by 6 further down
          op_nxt.slope = SUM_W'(slope_one_r) + (SUM_W'(slope_two_r) <<< 1)
                       + (SUM_W'(slope_three_r) <<< 1) + SUM_W'(in_ch.derivative);
          op_nxt.side.use_div       = 1'b1;
          op_nxt.side.step_complete = 1'b1;
          full_step_time_nxt        = eval_time_r;
          stage_nxt                 = STG_K1;
        end
        default: begin
          stage_nxt = STG_K1;
        end
      endcase
      op_nxt.side.stage_time = eval_time_nxt;
      op_nxt.side.step_time  = full_step_time_nxt;
    end
  end

  // Control and integrator state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_size_r      <= STEP_SIZE_RST;
      stage_r          <= STG_K1;
      start_value_r    <= '0;
      slope_one_r      <= '0;
      slope_two_r      <= '0;
      slope_three_r    <= '0;
      eval_time_r      <= '0;
      full_step_time_r <= '0;
      op_valid_r       <= 1'b0;
    end else begin
      step_size_r <= step_size_nxt;
      op_valid_r  <= op_valid_nxt;
      if (accept) begin
        stage_r          <= stage_nxt;
        start_value_r    <= start_value_nxt;
        slope_one_r      <= slope_one_nxt;
        slope_two_r      <= slope_two_nxt;
        slope_three_r    <= slope_three_nxt;
        eval_time_r      <= eval_time_nxt;
        full_step_time_r <= full_step_time_nxt;
      end
    end
  end

  // Operand register, loaded on transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= op_nxt;
    end
  end

endmodule

/* sv/rk4i_mul.sv */
// ---------------------------------------------------------------------------
// rk4i_mul
// Exact h * slope product: two partial products in one stage, their
// shifted sum in the next.
// ---------------------------------------------------------------------------
module rk4i_mul (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            op_valid,
  output logic            op_ready,
  input  rk4i_pkg::op_t   op,
  output logic            full_valid,
  input  logic            full_ready,
  output rk4i_pkg::full_t full
);
  import rk4i_pkg::*;

  logic                     p2_valid_r, p2_valid_nxt;
  logic                     p3_valid_r, p3_valid_nxt;
  prod_t                    p2_r, p2_nxt;
  full_t                    p3_r, p3_nxt;
  logic                     p2_ready, p3_ready;
  logic signed [PROD_W-1:0] hi_ext;
  logic signed [PROD_W-1:0] lo_ext;

  // Stage enables
  assign p3_ready   = !p3_valid_r || full_ready;
  assign p2_ready   = !p2_valid_r || p3_ready;
  assign op_ready   = p2_ready;
  assign full_valid = p3_valid_r;
  assign full       = p3_r;

  // Partial products: signed high slice and unsigned low slice of the slope
  always_comb begin
    p2_nxt.side    = op.side;
    p2_nxt.prod_hi = $signed({1'b0, op.mult}) * $signed(op.slope[SUM_W-1:LO_W]);
    p2_nxt.prod_lo = op.mult * op.slope[LO_W-1:0];
    p2_valid_nxt   = p2_ready ? op_valid : p2_valid_r;
  end

  // Recombine
  always_comb begin
    hi_ext       = PROD_W'(p2_r.prod_hi) <<< LO_W;
    lo_ext       = $signed(PROD_W'(p2_r.prod_lo));
    p3_nxt.side  = p2_r.side;
    p3_nxt.prod  = hi_ext + lo_ext;
    p3_valid_nxt = p3_ready ? p2_valid_r : p3_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_valid_r <= 1'b0;
      p3_valid_r <= 1'b0;
    end else begin
      p2_valid_r <= p2_valid_nxt;
      p3_valid_r <= p3_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (op_valid && p2_ready) begin
      p2_r <= p2_nxt;
    end
    if (p2_valid_r && p3_ready) begin
      p3_r <= p3_nxt;
    end
  end

endmodule

/* sv/rk4i_div.sv */
// ---------------------------------------------------------------------------
// rk4i_div
// Scales the product to Q16.16 with floor rounding: a plain shift for the
// first three stages, floor(p / (6 * 2^16)) for the last one, done as a
// shift by 17 and a two-part divide by 3.
// ---------------------------------------------------------------------------
module rk4i_div (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            full_valid,
  output logic            full_ready,
  input  rk4i_pkg::full_t full,
  output logic            inc_valid,
  input  logic            inc_ready,
  output rk4i_pkg::inc_t  inc
);
  import rk4i_pkg::*;

  logic               s4_valid_r, s4_valid_nxt;
  logic               s5_valid_r, s5_valid_nxt;
  split_t             s4_r, s4_nxt;
  inc_t               s5_r, s5_nxt;
  logic               s4_ready, s5_ready;
  logic [Q_W-2:0]     t_hi;
  logic [Q_W-1:0]     biased;
  logic [Q_W-2:0]     quo_b;
  logic [Q_W-2:0]     quo_hi_w;
  logic [Q_W-2:0]     quo_lo;

  assign s5_ready   = !s5_valid_r || inc_ready;
  assign s4_ready   = !s4_valid_r || s5_ready;
  assign full_ready = s4_ready;
  assign inc_valid  = s5_valid_r;
  assign inc        = s5_r;

  // High part: t = floor(p / 2^17) = t_hi * 2^24 + t_lo, then t_hi / 3
  always_comb begin
    t_hi     = full.prod[PROD_W-1:T_LSB+QLO_W];
    biased   = Q_W'($signed(t_hi)) + DIV3_BIAS;
    quo_b    = div3(biased);
    quo_hi_w = quo_b - {1'b1, {QLO_W{1'b0}}};

    s4_nxt.side    = full.side;
    s4_nxt.quo_hi  = quo_hi_w[QLO_W-1:0];
    s4_nxt.rem_hi  = mod3(biased);
    s4_nxt.t_lo    = full.prod[T_LSB +: QLO_W];
    s4_nxt.inc_dir = full.prod[PROD_W-1:FRAC_W];
    s4_valid_nxt   = s4_ready ? full_valid : s4_valid_r;
  end

  // Low part: (rem * 2^24 + t_lo) / 3 is below 2^24, so it simply appends
  always_comb begin
    quo_lo      = div3({s4_r.rem_hi, s4_r.t_lo});
    s5_nxt.side = s4_r.side;
    if (s4_r.side.use_div) begin
      s5_nxt.inc = INC_W'($signed({s4_r.quo_hi, quo_lo[QLO_W-1:0]}));
    end else begin
      s5_nxt.inc = s4_r.inc_dir;
    end
    s5_valid_nxt = s5_ready ? s4_valid_r : s5_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
      s5_valid_r <= 1'b0;
    end else begin
      s4_valid_r <= s4_valid_nxt;
      s5_valid_r <= s5_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (full_valid && s4_ready) begin
      s4_r <= s4_nxt;
    end
    if (s4_valid_r && s5_ready) begin
      s5_r <= s5_nxt;
    end
  end

endmodule

/* sv/rk4i_out.sv */
// ---------------------------------------------------------------------------
// rk4i_out
// Adds the increment to the start value, saturates to 32 bits and holds
// the result in the output register until it is taken.
// ---------------------------------------------------------------------------
module rk4i_out (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           inc_valid,
  output logic           inc_ready,
  input  rk4i_pkg::inc_t inc,
  rk4i_out_if.source     out_ch
);
  import rk4i_pkg::*;

  logic                    out_valid_r, out_valid_nxt;
  logic signed [VAL_W-1:0] next_value_r, next_value_nxt;
  logic [1:0]              stage_done_r;
  logic                    step_complete_r;
  logic [VAL_W-1:0]        stage_time_r;
  logic [VAL_W-1:0]        step_time_r;
  logic signed [SAT_W-1:0] sum;
  logic                    ovf;

  assign inc_ready            = !out_valid_r || out_ch.ready;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.next_value    = next_value_r;
  assign out_ch.stage_done    = stage_done_r;
  assign out_ch.step_complete = step_complete_r;
  assign out_ch.stage_time    = stage_time_r;
  assign out_ch.step_time     = step_time_r;

  // Add and saturate
  always_comb begin
    sum = SAT_W'(inc.side.x0) + SAT_W'(inc.inc);
    ovf = (sum[SAT_W-1:VAL_W-1] != '0) && (sum[SAT_W-1:VAL_W-1] != '1);
    if (ovf) begin
      next_value_nxt = sum[SAT_W-1] ? VAL_MIN : VAL_MAX;
    end else begin
      next_value_nxt = sum[VAL_W-1:0];
    end
    out_valid_nxt = inc_ready ? inc_valid : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (inc_valid && inc_ready) begin
      next_value_r    <= next_value_nxt;
      stage_done_r    <= inc.side.stage_done;
      step_complete_r <= inc.side.step_complete;
      stage_time_r    <= inc.side.stage_time;
      step_time_r     <= inc.side.step_time;
    end
  end

endmodule

/* sv/rk4_stage_integrator.sv */
// ---------------------------------------------------------------------------
// rk4_stage_integrator
// Classical fourth-order Runge-Kutta stepper for one Q16.16 state variable.
// ---------------------------------------------------------------------------
// Each evaluation item (value and derivative) advances the stage counter
// 0..3 and yields one result: the value at which to evaluate the derivative
// next, or, after stage 3, the new state with step_complete set. A restart
// item clears the stage and both clocks and echoes its value. The block is a
// six-register pipeline (operand, partial products, full product, two
// halves of the divide by 3, saturating output register) and takes one item
// per clock unless output backpressure stalls it; each result passes all six
// registers in order before it can transfer.
// The stage state is updated at the input transfer, so back-to-back items
// never wait on each other; the widest logic in any stage is a pair of
// partial-product multipliers of at most 32x18 bits, one 26-bit multiply by
// a constant, or one 66-bit add. Each stage stalls only when the one after
// it is full, so bubbles absorb output backpressure. Write the step size
// only while no item is in flight.
// ---------------------------------------------------------------------------
module rk4_stage_integrator (
  input  logic                        clk,
  input  logic                        rst_n,
  rk4i_in_if.sink                     in_ch,
  rk4i_out_if.source                  out_ch,
  input  logic                        cfg_we,
  input  logic [rk4i_pkg::STEP_W-1:0] cfg_data
);
  import rk4i_pkg::*;

  logic  op_valid, op_ready;
  op_t   op;
  logic  full_valid, full_ready;
  full_t full;
  logic  inc_valid, inc_ready;
  inc_t  inc;

  // Input stage and integrator state
  rk4i_ctl u_ctl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .op_valid (op_valid),
    .op_ready (op_ready),
    .op       (op)
  );

  // Exact product
  rk4i_mul u_mul (
    .clk        (clk),
    .rst_n      (rst_n),
    .op_valid   (op_valid),
    .op_ready   (op_ready),
    .op         (op),
    .full_valid (full_valid),
    .full_ready (full_ready),
    .full       (full)
  );

  // Scaling and divide by 6
  rk4i_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .full_valid (full_valid),
    .full_ready (full_ready),
    .full       (full),
    .inc_valid  (inc_valid),
    .inc_ready  (inc_ready),
    .inc        (inc)
  );

  // Saturating add and output register
  rk4i_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .inc_valid (inc_valid),
    .inc_ready (inc_ready),
    .inc       (inc),
    .out_ch    (out_ch)
  );

endmodule

/* sv/rk4i_chk.sv */
// ---------------------------------------------------------------------------
// rk4i_chk
// Port-level checks on the result channel of the stage integrator, bound
// to the top level.
// ---------------------------------------------------------------------------
module rk4i_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic signed [rk4i_pkg::VAL_W-1:0] next_value,
  input logic [1:0]                  stage_done,
  input logic                        step_complete,
  input logic [rk4i_pkg::VAL_W-1:0]  stage_time,
  input logic [rk4i_pkg::VAL_W-1:0]  step_time
);
  import rk4i_pkg::*;

  // No result right after reset
  a_rst_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(next_value)
      && $stable(stage_done) && $stable(step_time))
    else $error("stalled result changed");

  // Step completion only on the last stage
  a_cmp_stage: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && step_complete |-> stage_done == STG_K4)
    else $error("step complete outside the last stage");

  // A completed step stamps the step clock with the evaluation clock
  a_cmp_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && step_complete |-> step_time == stage_time)
    else $error("step time differs from stage time at completion");

endmodule

bind rk4_stage_integrator rk4i_chk u_rk4i_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .next_value    (out_ch.next_value),
  .stage_done    (out_ch.stage_done),
  .step_complete (out_ch.step_complete),
  .stage_time    (out_ch.stage_time),
  .step_time     (out_ch.step_time)
);
